### rtl/core/assert_macros.svh
// assertion macros used by the slot mapper rtl
// depends on a clk and an active-low rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define RSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define RSM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/rsm_pkg.sv
// types, constants and codes for the refcounted slot mapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rsm_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = 16;
  localparam int PAGE_W  = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_NEW       = 3'd1,
    ST_NOFREE    = 3'd2,
    ST_UNMAPPED  = 3'd3,
    ST_NOTMAPPED = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_FLUSHED   = 3'd6,
    ST_SATURATED = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LOOK  = 2'd1,
    S_APPLY = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [PAGE_W-1:0] page_id;
  } in_item_t;

  typedef struct packed {
    logic [5:0] slot;
    logic [2:0] status;
    logic       flush_done;
    logic       released;
  } out_item_t;

  // one slot entry as it travels along the ring
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [PAGE_W-1:0]  owner;
  } slot_ent_t;

  // ring control from the sequencer to the cells
  typedef struct packed {
    logic      shift;
    slot_ent_t wb;
  } ring_ctl_t;

endpackage
`default_nettype wire

### rtl/core/rsm_cell.sv
// one slot cell of the rotating ring: holds a count and an owner page
// depends on rsm_pkg
`timescale 1ns / 1ps
`default_nettype none
module rsm_cell
  import rsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      shift,
  input  wire slot_ent_t din,
  output slot_ent_t      dout
);

  logic [COUNT_W-1:0] count_r;
  logic [PAGE_W-1:0]  owner_r;

  // count clears at reset, owner is valid only where count is nonzero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (shift) begin
      count_r <= din.count;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      owner_r <= din.owner;
    end
  end

  assign dout.count = count_r;
  assign dout.owner = owner_r;

endmodule
`default_nettype wire

### rtl/core/rsm_ctrl.sv
// sequencer: looks at the ring head during a lookup pass, then edits the
// ring during an apply pass and forms the result; depends on rsm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rsm_ctrl
  import rsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire slot_ent_t head,
  output ring_ctl_t      ring
);

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]  k_r, k_nxt;
  logic [SLOT_W-1:0]  ptr_r;
  logic [1:0]         op_r;
  logic [PAGE_W-1:0]  page_r;
  logic               hit_r, hi_r, any_r;
  logic [SLOT_W-1:0]  hit_idx_r, hi_idx_r, any_idx_r;
  logic [COUNT_W-1:0] hit_cnt_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               in_acc, k_last, load_out;
  logic               ring_shift;
  logic               mod_flush, mod_new, mod_inc, mod_dec;
  logic [SLOT_W-1:0]  tgt;
  logic               ptr_wr;
  logic [SLOT_W-1:0]  ptr_val;
  out_item_t          res;
  logic               match;
  slot_ent_t          wb;

  assign in_acc   = in_valid && !in_stall;
  assign k_last   = (k_r == SLOT_W'(SLOTS - 1));
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign match    = (head.count != '0) && (head.owner == page_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  if (k_last) state_nxt = S_APPLY;
      S_APPLY: if (k_last) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    ring_shift = (state_r == S_LOOK) || (state_r == S_APPLY);
    k_nxt      = k_r;
    if (ring_shift) begin
      k_nxt = k_last ? '0 : k_r + 1'b1;
    end
  end

  // decision from the lookup pass
  always_comb begin
    mod_flush = 1'b0;
    mod_new   = 1'b0;
    mod_inc   = 1'b0;
    mod_dec   = 1'b0;
    tgt       = hit_idx_r;
    ptr_wr    = 1'b0;
    ptr_val   = ptr_r;
    res       = '0;
    res.status = ST_NOTMAPPED;
    unique case (op_r)
      OP_MAP: begin
        if (hit_r) begin
          res.slot = 6'(hit_idx_r);
          if (hit_cnt_r == COUNT_MAX) begin
            res.status = ST_SATURATED;
          end else begin
            mod_inc    = 1'b1;
            res.status = ST_HIT;
          end
        end else if (hi_r) begin
          mod_new    = 1'b1;
          tgt        = hi_idx_r;
          ptr_wr     = 1'b1;
          ptr_val    = hi_idx_r;
          res.slot   = 6'(hi_idx_r);
          res.status = ST_NEW;
        end else if (any_r) begin
          mod_flush      = 1'b1;
          mod_new        = 1'b1;
          tgt            = any_idx_r;
          ptr_wr         = 1'b1;
          ptr_val        = any_idx_r;
          res.slot       = 6'(any_idx_r);
          res.status     = ST_NEW;
          res.flush_done = 1'b1;
        end else begin
          mod_flush      = 1'b1;
          ptr_wr         = 1'b1;
          ptr_val        = SLOT_W'(SLOTS - 1);
          res.status     = ST_NOFREE;
          res.flush_done = 1'b1;
        end
      end
      OP_UNMAP: begin
        if (hit_r) begin
          res.slot = 6'(hit_idx_r);
          if (hit_cnt_r <= COUNT_W'(1)) begin
            res.status = ST_UNDERFLOW;
          end else begin
            mod_dec      = 1'b1;
            res.status   = ST_UNMAPPED;
            res.released = (hit_cnt_r == COUNT_W'(2));
          end
        end
      end
      OP_FLUSH: begin
        mod_flush      = 1'b1;
        res.status     = ST_FLUSHED;
        res.flush_done = 1'b1;
      end
      default: ;
    endcase
  end

  // write-back of the head entry into the ring tail
  always_comb begin
    wb = head;
    if (state_r == S_APPLY) begin
      if (mod_flush && head.count == COUNT_W'(1)) begin
        wb.count = '0;
      end
      if (k_r == tgt) begin
        if (mod_new) begin
          wb.count = COUNT_W'(2);
          wb.owner = page_r;
        end else if (mod_inc) begin
          wb.count = head.count + 1'b1;
        end else if (mod_dec) begin
          wb.count = head.count - 1'b1;
        end
      end
    end
  end

  // ring control to the cells
  assign ring = '{shift: ring_shift, wb: wb};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (state_r == S_APPLY && k_last && ptr_wr) begin
        ptr_r <= ptr_val;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction capture, lookup tracking and result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_data.op;
      page_r <= in_data.page_id;
      hit_r  <= 1'b0;
      hi_r   <= 1'b0;
      any_r  <= 1'b0;
    end else if (state_r == S_LOOK) begin
      if (!hit_r && match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= k_r;
        hit_cnt_r <= head.count;
      end
      if (!hi_r && head.count == '0 && k_r > ptr_r) begin
        hi_r     <= 1'b1;
        hi_idx_r <= k_r;
      end
      if (!any_r && head.count <= COUNT_W'(1)) begin
        any_r     <= 1'b1;
        any_idx_r <= k_r;
      end
    end
    if (load_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `RSM_ASSERT(a_idle_k0, (state_r == S_IDLE) |-> (k_r == '0), "ring not home when idle")
  `RSM_ASSERT(a_acc_look, in_acc |=> (state_r == S_LOOK), "accepted item did not start lookup")
  `RSM_ASSERT(a_apply_done, (state_r == S_APPLY && k_last) |=> (state_r == S_DONE),
              "apply pass did not end")
  `RSM_NEVER(a_one_edit, (state_r == S_APPLY) && $countones({mod_new, mod_inc, mod_dec}) > 1,
             "conflicting slot edits")

endmodule
`default_nettype wire

### rtl/core/refcounted_slot_mapper_core.sv
// top level of the refcounted slot mapper: ring of slot cells and sequencer
// depends on rsm_pkg, rsm_cell and rsm_ctrl
//
// usage: one transaction on in_ (op, page_id) gives exactly one transaction
// on out_ (slot, status, flush_done, released). map, unmap and flush-idle
// requests are served one at a time.
// the slot state sits in a ring of SLOTS cells that rotates one place per
// cycle while a lap runs; each request takes a lookup lap and an edit lap
// over the ring head, and the next request is taken the cycle after the
// result is registered. requests do not overlap: a new one is taken only
// once the last one is through both laps and its result is registered.
// in_stall is high from acceptance until the result is in the output
// register; a stall on out_ holds out_valid and out_data, and a finished
// result waits for the output register before the next request is taken.
// reset (rst_n low, synchronous) clears all use counts, the scan pointer and
// the output valid; owner pages need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_slot_mapper_core
  import rsm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  slot_ent_t ent [SLOTS];
  ring_ctl_t ring;

  // ring of cells, each takes its upper neighbor, the tail takes the write-back
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      rsm_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ring.shift),
        .din   (ring.wb),
        .dout  (ent[i])
      );
    end else begin : g_body
      rsm_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ring.shift),
        .din   (ent[i+1]),
        .dout  (ent[i])
      );
    end
  end

  // sequencer
  rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (ent[0]),
    .ring      (ring)
  );

endmodule
`default_nettype wire
